// ===== design/stramp_pkg.sv =====
package stramp_pkg;

    // Input function codes.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_RAMP  = 2'd1;
    localparam logic [1:0] FUNC_CONST = 2'd2;
    localparam logic [1:0] FUNC_LIMIT = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MIN_PERIOD = 2'd0;
    localparam logic [1:0] CFG_MAX_PERIOD = 2'd1;
    localparam logic [1:0] CFG_ACCEL_STEP = 2'd2;

    // Field and register widths fixed by the interface.
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int STEP_CNT_W  = 32;

    // Register reset values, before masking to the period width.
    localparam logic [31:0] MIN_PERIOD_RST = 32'd100;
    localparam logic [31:0] MAX_PERIOD_RST = 32'd2000;
    localparam logic [15:0] ACCEL_STEP_RST = 16'd10;

    // One result word.
    typedef struct packed {
        logic step_pulse;
        logic dir_out;
        logic enable_n;
        logic busy_res;
        logic move_done;
    } t_result;

endpackage

// ===== design/stepper_trapezoid_ramp.sv =====
// Step and direction generator for a stepper driver with trapezoidal ramping.
// Every input word is either a one-microsecond tick (func 0) or a start command
// for a ramped, constant-speed or move-to-limit move, and every input word yields
// exactly one result word. The block takes one word per clock cycle: all state
// updates for a word are done in the cycle it is accepted and its result lands
// in the output register, so a result shows in the cycle after its word is taken.
// i_ready of the result side is the only thing that throttles input: o_ready is
// high whenever the output register is empty or is being read in that cycle.
// Configuration writes take effect at the next clock edge and should only be
// issued while no move runs and no result is pending.
module stepper_trapezoid_ramp #(
    parameter int COUNT_WIDTH  = 32,
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [stramp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [stramp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input word channel.
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_func,
    input  logic                                i_direction,
    input  logic [stramp_pkg::STEP_CNT_W-1:0]   i_step_count,
    input  logic                                i_limit_switch,
    // Result word channel.
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_step_pulse,
    output logic                                o_dir_out,
    output logic                                o_enable_n,
    output logic                                o_busy_res,
    output logic                                o_move_done
);
    import stramp_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int PW = PERIOD_WIDTH;

    // Configuration registers.
    logic [PW-1:0] r_min_period;
    logic [PW-1:0] r_max_period;
    logic [15:0]   r_accel_step;

    // Move state.
    logic          r_active,      n_active;
    logic [1:0]    r_move_mode,   n_move_mode;
    logic          r_dir_reg,     n_dir_reg;
    logic [CW-1:0] r_steps_left,  n_steps_left;
    logic [CW-1:0] r_decel_start, n_decel_start;
    logic [CW-1:0] r_accel_stop,  n_accel_stop;
    logic [PW-1:0] r_cur_period,  n_cur_period;
    logic [PW-1:0] r_wait_timer,  n_wait_timer;
    logic          r_pulse_phase, n_pulse_phase;

    // Output register.
    logic          r_out_valid;
    t_result       r_result,      n_result;

    logic          w_in_accept;
    logic [31:0]   w_cfg_ext;
    logic [CW-1:0] w_count;
    logic [PW:0]   w_period_sum;
    logic [PW-1:0] w_mean_period;
    logic [31:0]   w_accel_ext;
    logic [PW-1:0] w_down_gap;
    logic [PW-1:0] w_up_gap;
    logic [PW-1:0] w_ramp_period;

    assign o_ready     = !r_out_valid || i_ready;
    assign w_in_accept = i_valid && o_ready;

    // Configuration writes; periods are kept at the period width.
    assign w_cfg_ext = 32'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period <= MIN_PERIOD_RST[PW-1:0];
            r_max_period <= MAX_PERIOD_RST[PW-1:0];
            r_accel_step <= ACCEL_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_PERIOD: r_min_period <= w_cfg_ext[PW-1:0];
                CFG_MAX_PERIOD: r_max_period <= w_cfg_ext[PW-1:0];
                CFG_ACCEL_STEP: r_accel_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Shared arithmetic: mean period and the ramp step of the current period.
    assign w_count       = i_step_count[CW-1:0];
    assign w_period_sum  = {1'b0, r_min_period} + {1'b0, r_max_period};
    assign w_mean_period = w_period_sum[PW:1];
    assign w_accel_ext   = 32'(r_accel_step);
    assign w_down_gap    = r_cur_period - r_min_period;
    assign w_up_gap      = r_max_period - r_cur_period;

    // Ramp update, evaluated against the count of steps still to run.
    always_comb begin
        w_ramp_period = r_cur_period;
        if (r_steps_left >= r_accel_stop) begin
            if (r_cur_period > r_min_period) begin
                w_ramp_period = (32'(w_down_gap) > w_accel_ext)
                              ? r_cur_period - w_accel_ext[PW-1:0] : r_min_period;
            end
        end else if (r_steps_left < r_decel_start) begin
            if (r_cur_period < r_max_period) begin
                w_ramp_period = (32'(w_up_gap) > w_accel_ext)
                              ? r_cur_period + w_accel_ext[PW-1:0] : r_max_period;
            end
        end
    end

    // Next state and result for the word at the input.
    always_comb begin
        logic step_over;
        logic move_end;
        logic pulse;
        logic done;

        n_active      = r_active;
        n_move_mode   = r_move_mode;
        n_dir_reg     = r_dir_reg;
        n_steps_left  = r_steps_left;
        n_decel_start = r_decel_start;
        n_accel_stop  = r_accel_stop;
        n_cur_period  = r_cur_period;
        n_wait_timer  = r_wait_timer;
        n_pulse_phase = r_pulse_phase;
        step_over     = 1'b0;
        move_end      = 1'b0;
        pulse         = 1'b0;
        done          = 1'b0;

        if (i_func != FUNC_TICK && !r_active) begin
            // Start of a move: latch it, the first high tick follows.
            n_move_mode   = i_func;
            n_dir_reg     = i_direction;
            n_pulse_phase = 1'b0;
            n_wait_timer  = '0;
            n_steps_left  = w_count;
            n_decel_start = w_count >> 2;
            n_accel_stop  = w_count - (w_count >> 2);
            n_cur_period  = (i_func == FUNC_RAMP) ? r_max_period : w_mean_period;
            if (i_func != FUNC_LIMIT && w_count == '0) begin
                done = 1'b1;
            end else begin
                n_active = 1'b1;
            end
        end else if (r_active) begin
            // Step timing: one high tick, then the period in low ticks.
            if (!r_pulse_phase) begin
                pulse = 1'b1;
                if (r_cur_period == '0) begin
                    step_over = 1'b1;
                end else begin
                    n_wait_timer  = r_cur_period;
                    n_pulse_phase = 1'b1;
                end
            end else begin
                n_wait_timer = r_wait_timer - 1'b1;
                if (r_wait_timer == PW'(1)) begin
                    n_pulse_phase = 1'b0;
                    step_over     = 1'b1;
                end
            end

            // End of a step: ramp, count down, or test the limit switch.
            if (step_over) begin
                if (r_move_mode == FUNC_LIMIT) begin
                    move_end = !i_limit_switch;
                end else begin
                    if (r_move_mode == FUNC_RAMP) begin
                        n_cur_period = w_ramp_period;
                    end
                    n_steps_left = r_steps_left - 1'b1;
                    move_end     = (r_steps_left == CW'(1));
                end
            end

            if (move_end) begin
                n_active      = 1'b0;
                n_pulse_phase = 1'b0;
                n_wait_timer  = '0;
                done          = 1'b1;
            end
        end

        n_result.step_pulse = pulse;
        n_result.dir_out    = n_dir_reg;
        n_result.enable_n   = !n_active;
        n_result.busy_res   = n_active;
        n_result.move_done  = done;
    end

    // State registers advance once per accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_move_mode   <= FUNC_TICK;
            r_dir_reg     <= 1'b0;
            r_steps_left  <= '0;
            r_decel_start <= '0;
            r_accel_stop  <= '0;
            r_cur_period  <= '0;
            r_wait_timer  <= '0;
            r_pulse_phase <= 1'b0;
        end else if (w_in_accept) begin
            r_active      <= n_active;
            r_move_mode   <= n_move_mode;
            r_dir_reg     <= n_dir_reg;
            r_steps_left  <= n_steps_left;
            r_decel_start <= n_decel_start;
            r_accel_stop  <= n_accel_stop;
            r_cur_period  <= n_cur_period;
            r_wait_timer  <= n_wait_timer;
            r_pulse_phase <= n_pulse_phase;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_step_pulse = r_result.step_pulse;
    assign o_dir_out    = r_result.dir_out;
    assign o_enable_n   = r_result.enable_n;
    assign o_busy_res   = r_result.busy_res;
    assign o_move_done  = r_result.move_done;

    // A finishing word never reports the move as still running.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_move_done |-> !o_busy_res && o_enable_n)
        else $error("move_done reported together with busy");

    // An idle block holds no pending pulse timing.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> !r_pulse_phase && r_wait_timer == '0)
        else $error("idle with pulse timing still pending");

    // The busy flag of a result matches the move state it left behind.
    a_busy_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_busy_res == r_active)
        else $error("busy result disagrees with move state");

    // While the low time runs, the timer is never zero.
    a_timer_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && r_pulse_phase |-> r_wait_timer != '0)
        else $error("low phase with expired timer");

endmodule
